// File: hw/rtl/iwc_pkg.sv
package iwc_pkg;

  localparam int SIDE_BITS = 6;
  localparam int SITE_BITS = 2 * SIDE_BITS;
  localparam int SITES = 1 << SITE_BITS;
  localparam int STACK_BITS = 14;
  localparam int STACK_DEPTH = 1 << STACK_BITS;
  localparam int COUNT_BITS = SITE_BITS + 1;

  typedef logic [SITE_BITS-1:0] site_t;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_GROW  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_SEED      = 1'b1;

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  function automatic site_t neighbour(input site_t s, input logic [1:0] dir);
    logic [SIDE_BITS-1:0] r;
    logic [SIDE_BITS-1:0] c;
    r = s[SITE_BITS-1:SIDE_BITS];
    c = s[SIDE_BITS-1:0];
    unique case (dir)
      2'd0: r = r - 1'b1;
      2'd1: r = r + 1'b1;
      2'd2: c = c - 1'b1;
      default: c = c + 1'b1;
    endcase
    return {r, c};
  endfunction

endpackage

// File: hw/rtl/iwc_rng.sv
module iwc_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [31:0] load_value,
  input  logic        advance,
  output logic [15:0] draw
);

  logic [31:0] word;
  logic [31:0] word_next;

  assign word_next = iwc_pkg::xorshift(word);
  assign draw = word_next[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= 32'd1;
    end else if (load) begin
      word <= (load_value == 32'd0) ? 32'd1 : load_value;
    end else if (advance) begin
      word <= word_next;
    end
  end

endmodule

// File: hw/rtl/ising_wolff_cluster_flip_core.sv
// Wolff cluster engine for a 64 x 64 periodic Ising lattice held in on-chip
// memories (spin plus mark per site, member list, candidate stack). A grow
// item reads and checks the four neighbours of each cluster member, tests
// each stack entry that it pops and ends with a flip and unmark pass over
// the member list. All memories are single ported, so the serial walk of
// the site memory sets the time. The result sits in an output register, so
// the next item can be taken and worked on while a result waits on
// out_stall. After reset a clearing pass zeroes the site memory before the
// first item is taken. Configuration writes are taken at any time and must
// only be made while the block is idle.
module ising_wolff_cluster_flip_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [5:0]  row,
  input  logic [5:0]  column,
  input  logic        spin_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        spin_out,
  output logic [12:0] flipped_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ACC, S_RDWAIT, S_SEEDRD, S_NBRD, S_NBCHK, S_POP,
    S_POPRD, S_CANDRD, S_CANDCHK, S_FLIPRD, S_FLIPRDW, S_FLIPWR, S_DONE
  } state_t;

  state_t state;

  // site memory: bit 1 spin, bit 0 member mark
  logic [1:0] site_mem [iwc_pkg::SITES];
  logic [iwc_pkg::SITE_BITS-1:0] site_member [iwc_pkg::SITES];
  logic [iwc_pkg::SITE_BITS-1:0] stack_mem [iwc_pkg::STACK_DEPTH];

  logic                          site_we;
  iwc_pkg::site_t                site_addr;
  logic [1:0]                    site_wdata;
  logic [1:0]                    site_q;
  logic                          list_we;
  logic [iwc_pkg::SITE_BITS-1:0] list_addr;
  iwc_pkg::site_t                list_q;
  logic                          stk_we;
  logic [iwc_pkg::STACK_BITS-1:0] stk_addr;
  iwc_pkg::site_t                stk_wdata;
  iwc_pkg::site_t                stk_q;

  logic [1:0]                    req_kind;
  iwc_pkg::site_t                req_site;
  logic                          req_spin;
  iwc_pkg::site_t                cur;
  logic                          cur_spin;
  logic [1:0]                    dir;
  logic                          check_mark;
  logic [iwc_pkg::STACK_BITS:0]  sp;
  logic [iwc_pkg::COUNT_BITS-1:0] count;
  logic [iwc_pkg::COUNT_BITS-1:0] idx;
  iwc_pkg::site_t                clr;
  logic [15:0]                   threshold;
  logic [15:0]                   draw;
  logic                          rng_adv;
  iwc_pkg::site_t                nb;
  logic                          res_spin;
  logic [12:0]                   res_count;

  assign nb = iwc_pkg::neighbour(cur, dir);
  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (site_we) site_mem[site_addr] <= site_wdata;
    site_q <= site_mem[site_addr];
  end

  always_ff @(posedge clk) begin
    if (list_we) site_member[list_addr] <= cur;
    list_q <= site_member[list_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_addr] <= stk_wdata;
    stk_q <= stack_mem[stk_addr];
  end

  iwc_rng u_rng (
    .clk        (clk),
    .rst        (rst),
    .load       (cfg_valid && cfg_index == iwc_pkg::CFG_SEED),
    .load_value (cfg_data),
    .advance    (rng_adv),
    .draw       (draw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= 16'd0;
    end else if (cfg_valid && cfg_index == iwc_pkg::CFG_THRESHOLD) begin
      threshold <= cfg_data[15:0];
    end
  end

  always_comb begin
    site_we = 1'b0;
    site_addr = cur;
    site_wdata = 2'b00;
    list_we = 1'b0;
    list_addr = count[iwc_pkg::SITE_BITS-1:0];
    stk_we = 1'b0;
    stk_addr = sp[iwc_pkg::STACK_BITS-1:0];
    stk_wdata = nb;
    rng_adv = 1'b0;
    unique case (state)
      S_CLEAR: begin
        site_we = 1'b1;
        site_addr = clr;
      end
      S_ACC: begin
        site_addr = req_site;
        if (req_kind == iwc_pkg::KIND_WRITE) begin
          site_we = 1'b1;
          site_wdata = {req_spin, 1'b0};
        end
      end
      S_SEEDRD: begin
        site_we = 1'b1;
        site_wdata = {site_q[1], 1'b1};
        list_we = 1'b1;
      end
      S_NBRD: site_addr = nb;
      S_NBCHK: begin
        stk_we = (site_q[1] == cur_spin) && !(check_mark && site_q[0])
                 && (sp != (iwc_pkg::STACK_BITS+1)'(iwc_pkg::STACK_DEPTH));
      end
      S_POP: stk_addr = sp[iwc_pkg::STACK_BITS-1:0] - 1'b1;
      S_CANDRD: site_addr = stk_q;
      S_CANDCHK: begin
        site_addr = cur;
        if (!site_q[0]) begin
          rng_adv = 1'b1;
          if (draw < threshold) begin
            site_we = 1'b1;
            site_wdata = {cur_spin, 1'b1};
            list_we = 1'b1;
          end
        end
      end
      S_FLIPRD: list_addr = idx[iwc_pkg::SITE_BITS-1:0];
      S_FLIPRDW: site_addr = list_q;
      S_FLIPWR: begin
        site_addr = cur;
        site_we = 1'b1;
        site_wdata = {~site_q[1], 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
      sp <= '0;
      count <= '0;
      spin_out <= 1'b0;
      flipped_count <= '0;
      res_spin <= 1'b0;
      res_count <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            req_kind <= kind;
            req_site <= {row, column};
            req_spin <= spin_in;
            cur <= {row, column};
            state <= S_ACC;
          end
        end
        S_ACC: begin
          sp <= '0;
          count <= '0;
          dir <= 2'd0;
          check_mark <= 1'b0;
          unique case (req_kind)
            iwc_pkg::KIND_READ: state <= S_RDWAIT;
            iwc_pkg::KIND_GROW: state <= S_SEEDRD;
            default: begin
              res_spin <= 1'b0;
              res_count <= '0;
              state <= S_DONE;
            end
          endcase
        end
        S_RDWAIT: begin
          res_spin <= site_q[1];
          res_count <= '0;
          state <= S_DONE;
        end
        S_SEEDRD: begin
          cur_spin <= site_q[1];
          count <= count + 1'b1;
          state <= S_NBRD;
        end
        S_NBRD: state <= S_NBCHK;
        S_NBCHK: begin
          if (stk_we) sp <= sp + 1'b1;
          dir <= dir + 1'b1;
          state <= (dir == 2'd3) ? S_POP : S_NBRD;
        end
        S_POP: begin
          if (sp == '0) begin
            idx <= '0;
            state <= S_FLIPRD;
          end else begin
            sp <= sp - 1'b1;
            state <= S_POPRD;
          end
        end
        S_POPRD: state <= S_CANDRD;
        S_CANDRD: begin
          cur <= stk_q;
          state <= S_CANDCHK;
        end
        S_CANDCHK: begin
          if (!site_q[0] && draw < threshold) begin
            count <= count + 1'b1;
            check_mark <= 1'b1;
            dir <= 2'd0;
            state <= S_NBRD;
          end else begin
            state <= S_POP;
          end
        end
        S_FLIPRD: begin
          if (idx == count) begin
            res_spin <= 1'b0;
            res_count <= count;
            state <= S_DONE;
          end else begin
            state <= S_FLIPRDW;
          end
        end
        S_FLIPRDW: begin
          cur <= list_q;
          state <= S_FLIPWR;
        end
        S_FLIPWR: begin
          idx <= idx + 1'b1;
          state <= S_FLIPRD;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            spin_out <= res_spin;
            flipped_count <= res_count;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("item taken while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flipped_count <= 13'(iwc_pkg::SITES)))
    else $error("cluster size out of range");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(flipped_count)
                                  && $stable(spin_out)))
    else $error("stalled result changed");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = iwc_pkg::KIND_NONE;
  logic [5:0]  row = '0;
  logic [5:0]  column = '0;
  logic        spin_in = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        spin_out;
  logic [12:0] flipped_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = iwc_pkg::CFG_THRESHOLD;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic        spin;
    logic [12:0] count;
  } lattice_result_t;

  // lattice shadow
  logic [iwc_pkg::SITES-1:0] lattice_spin;
  logic [iwc_pkg::SITES-1:0] lattice_mark;
  logic [15:0]      bond_threshold;
  logic [31:0]      xorshift_word;
  iwc_pkg::site_t   stack_shadow [iwc_pkg::STACK_DEPTH];
  iwc_pkg::site_t   member_shadow [iwc_pkg::SITES];
  lattice_result_t  pending_results[$];
  int               error_count = 0;
  bit               quiet_mode = 1'b0;
  int               stall_hold_req = 0;

  ising_wolff_cluster_flip_core dut (.*);

  always #6 clk = ~clk;

  function automatic logic [15:0] next_draw();
    logic [31:0] x;
    x = xorshift_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    xorshift_word = x;
    return x[31:16];
  endfunction

  function automatic iwc_pkg::site_t step_site(input iwc_pkg::site_t s, input int dir);
    logic [5:0] r;
    logic [5:0] c;
    r = s[11:6];
    c = s[5:0];
    case (dir)
      0: r = r - 6'd1;
      1: r = r + 6'd1;
      2: c = c - 6'd1;
      default: c = c + 6'd1;
    endcase
    return {r, c};
  endfunction

  function automatic logic [12:0] flip_cluster(input iwc_pkg::site_t seed);
    iwc_pkg::site_t cand;
    iwc_pkg::site_t nb;
    int top;
    int n_members;
    top = 0;
    n_members = 0;
    lattice_mark[seed] = 1'b1;
    member_shadow[n_members] = seed;
    n_members++;
    for (int d = 0; d < 4; d++) begin
      nb = step_site(seed, d);
      if (lattice_spin[nb] == lattice_spin[seed] && top < iwc_pkg::STACK_DEPTH) begin
        stack_shadow[top] = nb;
        top++;
      end
    end
    while (top > 0) begin
      top--;
      cand = stack_shadow[top];
      if (!lattice_mark[cand] && next_draw() < bond_threshold) begin
        lattice_mark[cand] = 1'b1;
        if (n_members < iwc_pkg::SITES) begin
          member_shadow[n_members] = cand;
          n_members++;
        end
        for (int d = 0; d < 4; d++) begin
          nb = step_site(cand, d);
          if (lattice_spin[nb] == lattice_spin[cand] && !lattice_mark[nb] &&
              top < iwc_pkg::STACK_DEPTH) begin
            stack_shadow[top] = nb;
            top++;
          end
        end
      end
    end
    for (int k = 0; k < n_members; k++) begin
      lattice_spin[member_shadow[k]] = ~lattice_spin[member_shadow[k]];
      lattice_mark[member_shadow[k]] = 1'b0;
    end
    return 13'(n_members);
  endfunction

  function automatic lattice_result_t predict_item(input iwc_pkg::kind_t k,
                                                   input logic [5:0] r,
                                                   input logic [5:0] c, input logic s);
    lattice_result_t res;
    iwc_pkg::site_t site;
    res = '0;
    site = {r, c};
    case (k)
      iwc_pkg::KIND_WRITE: lattice_spin[site] = s;
      iwc_pkg::KIND_READ:  res.spin = lattice_spin[site];
      iwc_pkg::KIND_GROW:  res.count = flip_cluster(site);
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // result checker
  always @(posedge clk) begin
    lattice_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (spin_out !== exp_res.spin)
          report_mismatch($sformatf("spin_out %0b expected %0b", spin_out, exp_res.spin));
        if (flipped_count !== exp_res.count)
          report_mismatch($sformatf("flipped_count %0d expected %0d",
                                    flipped_count, exp_res.count));
      end
    end
  end

  // receiver stall, with long hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    if (stall_hold_req > 0) begin
      hold_left = stall_hold_req;
      stall_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_mode && ($urandom_range(99) < 22);
    end
  end

  task automatic send_item(input iwc_pkg::kind_t k, input logic [5:0] r,
                           input logic [5:0] c, input logic s);
    while (!quiet_mode && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    row <= r;
    column <= c;
    spin_in <= s;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), predict_item(k, r, c, s));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == iwc_pkg::CFG_THRESHOLD) begin
      bond_threshold = value[15:0];
    end else begin
      xorshift_word = (value == 0) ? 32'd1 : value;
    end
  endtask

  task automatic send_random_item(input int grow_pct);
    int pick;
    iwc_pkg::kind_t k;
    pick = $urandom_range(99);
    if (pick < grow_pct) k = iwc_pkg::KIND_GROW;
    else if (pick < grow_pct + 40) k = iwc_pkg::KIND_WRITE;
    else if (pick < 95) k = iwc_pkg::KIND_READ;
    else k = iwc_pkg::KIND_NONE;
    send_item(k, 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic test_directed();
    send_item(iwc_pkg::KIND_READ, 6'd0, 6'd0, 1'b1);
    send_item(iwc_pkg::KIND_READ, 6'd63, 6'd63, 1'b0);
    send_item(iwc_pkg::KIND_WRITE, 6'd63, 6'd0, 1'b1);
    send_item(iwc_pkg::KIND_READ, 6'd63, 6'd0, 1'b0);
    send_item(iwc_pkg::KIND_WRITE, 6'd0, 6'd63, 1'b1);
    send_item(iwc_pkg::KIND_WRITE, 6'd0, 6'd63, 1'b0);
    send_item(iwc_pkg::KIND_READ, 6'd0, 6'd63, 1'b1);
    send_item(iwc_pkg::KIND_NONE, 6'd63, 6'd63, 1'b1);
    send_item(iwc_pkg::KIND_READ, 6'd63, 6'd63, 1'b0);
    // threshold zero: seed alone flips
    send_item(iwc_pkg::KIND_GROW, 6'd0, 6'd0, 1'b0);
    send_item(iwc_pkg::KIND_READ, 6'd0, 6'd0, 1'b0);
    write_register(iwc_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
    write_register(iwc_pkg::CFG_SEED, 32'd0);
    // nearly whole lattice joins across wrapped edges
    send_item(iwc_pkg::KIND_GROW, 6'd63, 6'd63, 1'b0);
    send_item(iwc_pkg::KIND_READ, 6'd31, 6'd17, 1'b0);
    send_item(iwc_pkg::KIND_READ, 6'd0, 6'd0, 1'b0);
    write_register(iwc_pkg::CFG_SEED, 32'hFFFF_FFFF);
    write_register(iwc_pkg::CFG_THRESHOLD, 32'd1);
    send_item(iwc_pkg::KIND_GROW, 6'd32, 6'd32, 1'b1);
    send_item(iwc_pkg::KIND_NONE, 6'd0, 6'd0, 1'b0);
  endtask

  task automatic test_random_phases();
    logic [15:0] thresholds[5] = '{16'd0, 16'd12000, 16'd24000, 16'd30000, 16'd40000};
    for (int p = 0; p < 5; p++) begin
      write_register(iwc_pkg::CFG_THRESHOLD, {16'($urandom), thresholds[p]});
      write_register(iwc_pkg::CFG_SEED, $urandom);
      for (int n = 0; n < 280; n++) send_random_item(p == 4 ? 5 : 25);
    end
  endtask

  task automatic test_backpressure();
    write_register(iwc_pkg::CFG_THRESHOLD, 32'd20000);
    stall_hold_req = 400;
    for (int n = 0; n < 40; n++) send_random_item(30);
    drain_results();
    for (int n = 0; n < 20; n++) send_random_item(30);
  endtask

  task automatic test_no_idle();
    quiet_mode = 1'b1;
    for (int n = 0; n < 200; n++) send_random_item(25);
    quiet_mode = 1'b0;
  endtask

  initial begin
    lattice_spin = '0;
    lattice_mark = '0;
    bond_threshold = '0;
    xorshift_word = 32'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    test_no_idle();
    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(12 * 40_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: ising_wolff_cluster_flip_core.f
hw/rtl/iwc_pkg.sv
hw/rtl/iwc_rng.sv
hw/rtl/ising_wolff_cluster_flip_core.sv
dv/testbench.sv
